FILE: hw/rtl/bmhq_pkg.sv
package bmhq_pkg;

    // Storage geometry
    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CHILD_W = ADDR_W + 2;   // holds 2*node+2

    // Item field widths
    localparam int VALUE_W = 32;
    localparam int POS_W   = 10;
    localparam int STAT_W  = 2;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_OCC = 2'd2;

    // Read address select
    typedef enum logic [2:0] {
        RD_POS,
        RD_LAST,
        RD_PARENT,
        RD_LEFT,
        RD_RIGHT
    } t_rd_sel;

    // Write data select
    typedef enum logic [1:0] {
        WR_VAL,
        WR_RDATA,
        WR_CAND
    } t_wr_sel;

    // Controller -> datapath
    typedef struct packed {
        logic                load_item;
        logic                ins_setup;
        logic                load_node_pos;
        t_rd_sel             rd_sel;
        logic                wr_en;
        t_wr_sel             wr_sel;
        logic                node_to_parent;
        logic                node_to_cand;
        logic                cap_removed;
        logic                cap_last;
        logic                cap_left;
        logic                cap_right;
        logic                status_wr;
        logic [STAT_W-1:0]   status_code;
        logic                out_load;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic is_remove;
        logic full;
        logic pos_bad;
        logic pos_is_last;
        logic node_zero;
        logic v_gt_rdata;
        logic left_out;
        logic right_out;
        logic rdata_gt_cand;
        logic cand_gt_v;
    } t_dp_stat;

endpackage

FILE: hw/rtl/binary_max_heap_queue_core.sv
// Throughput: one item at a time; the per-level cost is set by the single read port of
//   the heap array.
// Reset: synchronous active low; clears the count and the controller, not the heap array.
module binary_max_heap_queue_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [31:0] value, [41:32] position, [47:42] zero
    input  logic        s_axis_tuser,   // [0] command: 0 insert, 1 remove at position
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // [31:0] removed_value, [63:32] top_value,
                                        // [74:64] count, [76:75] status, [79:77] zero
);

    bmhq_pkg::t_dp_cmd  w_cmd;
    bmhq_pkg::t_dp_stat w_stat;

    logic [bmhq_pkg::VALUE_W-1:0] w_removed;
    logic [bmhq_pkg::VALUE_W-1:0] w_top;
    logic [bmhq_pkg::CNT_W-1:0]   w_count;
    logic [bmhq_pkg::STAT_W-1:0]  w_status;

    // Controller: sequences reads, compares and writes of each sift level, and holds
    // the result register valid until the downstream side takes it.
    bmhq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    // Datapath: heap array, moving value, node pointer, count, result registers.
    // Sifting moves a hole rather than swapping, so each level costs one write.
    bmhq_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_cmd   (s_axis_tuser),
        .i_item_value (s_axis_tdata[31:0]),
        .i_item_pos   (s_axis_tdata[41:32]),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_removed    (w_removed),
        .o_top        (w_top),
        .o_count      (w_count),
        .o_status     (w_status)
    );

    assign m_axis_tdata = {3'b000, w_status, w_count, w_top, w_removed};

    // the block goes busy right after it takes an item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready stayed high after an accepted item");

    // heap writes only happen while an item is in progress
    a_no_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.wr_en |-> !s_axis_tready)
        else $error("heap write while idle");

    // a refused insert reports a full heap
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[76:75] == bmhq_pkg::ST_FULL))
        |-> (m_axis_tdata[74:64] == bmhq_pkg::CNT_W'(bmhq_pkg::DEPTH)))
        else $error("full status with count below depth");

    // a failed remove takes nothing out
    a_notocc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[76:75] == bmhq_pkg::ST_NOT_OCC))
        |-> (m_axis_tdata[31:0] == '0))
        else $error("nonzero removed value on a failed remove");

endmodule

FILE: hw/rtl/bmhq_dp.sv
module bmhq_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_item_cmd,
    input  logic [bmhq_pkg::VALUE_W-1:0]      i_item_value,
    input  logic [bmhq_pkg::POS_W-1:0]        i_item_pos,
    input  bmhq_pkg::t_dp_cmd                 i_cmd,
    output bmhq_pkg::t_dp_stat                o_stat,
    output logic [bmhq_pkg::VALUE_W-1:0]      o_removed,
    output logic [bmhq_pkg::VALUE_W-1:0]      o_top,
    output logic [bmhq_pkg::CNT_W-1:0]        o_count,
    output logic [bmhq_pkg::STAT_W-1:0]       o_status
);

    localparam int CMP_W = bmhq_pkg::POS_W + bmhq_pkg::CNT_W;

    logic [bmhq_pkg::VALUE_W-1:0] mem [bmhq_pkg::DEPTH];

    logic                          r_cmd;
    logic [bmhq_pkg::VALUE_W-1:0]  r_val;
    logic [bmhq_pkg::POS_W-1:0]    r_pos;
    logic [bmhq_pkg::ADDR_W-1:0]   r_node;
    logic [bmhq_pkg::CNT_W-1:0]    r_count;
    logic [bmhq_pkg::VALUE_W-1:0]  r_removed;
    logic [bmhq_pkg::STAT_W-1:0]   r_status;
    logic [bmhq_pkg::VALUE_W-1:0]  r_top;
    logic [bmhq_pkg::VALUE_W-1:0]  r_rdata;
    logic [bmhq_pkg::VALUE_W-1:0]  r_cand;
    logic [bmhq_pkg::ADDR_W-1:0]   r_cand_idx;
    logic [bmhq_pkg::VALUE_W-1:0]  r_o_removed;
    logic [bmhq_pkg::VALUE_W-1:0]  r_o_top;
    logic [bmhq_pkg::CNT_W-1:0]    r_o_count;
    logic [bmhq_pkg::STAT_W-1:0]   r_o_status;

    logic [bmhq_pkg::ADDR_W-1:0]   w_parent;
    logic [bmhq_pkg::CHILD_W-1:0]  w_left;
    logic [bmhq_pkg::CHILD_W-1:0]  w_right;
    logic [bmhq_pkg::CHILD_W-1:0]  w_count_c;
    logic [bmhq_pkg::CNT_W-1:0]    w_last;
    logic [bmhq_pkg::ADDR_W-1:0]   w_raddr;
    logic [bmhq_pkg::VALUE_W-1:0]  w_wdata;

    assign w_parent  = (r_node - bmhq_pkg::ADDR_W'(1)) >> 1;
    assign w_left    = bmhq_pkg::CHILD_W'({r_node, 1'b1});
    assign w_right   = w_left + bmhq_pkg::CHILD_W'(1);
    assign w_count_c = bmhq_pkg::CHILD_W'(r_count);
    assign w_last    = r_count - bmhq_pkg::CNT_W'(1);

    always_comb begin
        case (i_cmd.rd_sel)
            bmhq_pkg::RD_POS:    w_raddr = bmhq_pkg::ADDR_W'(r_pos);
            bmhq_pkg::RD_LAST:   w_raddr = w_last[bmhq_pkg::ADDR_W-1:0];
            bmhq_pkg::RD_PARENT: w_raddr = w_parent;
            bmhq_pkg::RD_LEFT:   w_raddr = w_left[bmhq_pkg::ADDR_W-1:0];
            bmhq_pkg::RD_RIGHT:  w_raddr = w_right[bmhq_pkg::ADDR_W-1:0];
            default:             w_raddr = r_node;
        endcase
    end

    always_comb begin
        case (i_cmd.wr_sel)
            bmhq_pkg::WR_VAL:   w_wdata = r_val;
            bmhq_pkg::WR_RDATA: w_wdata = r_rdata;
            bmhq_pkg::WR_CAND:  w_wdata = r_cand;
            default:            w_wdata = r_val;
        endcase
    end

    // heap array: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[r_node] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.ins_setup) begin
            r_count <= r_count + bmhq_pkg::CNT_W'(1);
        end else if (i_cmd.cap_last) begin
            r_count <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cmd     <= i_item_cmd;
            r_val     <= i_item_value;
            r_pos     <= i_item_pos;
            r_removed <= '0;
            r_status  <= bmhq_pkg::ST_OK;
        end
        if (i_cmd.ins_setup) begin
            r_node <= r_count[bmhq_pkg::ADDR_W-1:0];
        end else if (i_cmd.load_node_pos) begin
            r_node <= bmhq_pkg::ADDR_W'(r_pos);
        end else if (i_cmd.node_to_parent) begin
            r_node <= w_parent;
        end else if (i_cmd.node_to_cand) begin
            r_node <= r_cand_idx;
        end
        if (i_cmd.cap_removed) begin
            r_removed <= r_rdata;
        end
        if (i_cmd.cap_last) begin
            r_val <= r_rdata;
        end
        if (i_cmd.status_wr) begin
            r_status <= i_cmd.status_code;
        end
        // shadow of slot 0
        if (i_cmd.wr_en && (r_node == '0)) begin
            r_top <= w_wdata;
        end
        if (i_cmd.cap_left) begin
            r_cand     <= r_rdata;
            r_cand_idx <= w_left[bmhq_pkg::ADDR_W-1:0];
        end else if (i_cmd.cap_right) begin
            r_cand     <= r_rdata;
            r_cand_idx <= w_right[bmhq_pkg::ADDR_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_o_removed <= r_removed;
            r_o_top     <= (r_count != '0) ? r_top : '0;
            r_o_count   <= r_count;
            r_o_status  <= r_status;
        end
    end

    always_comb begin
        o_stat.is_remove     = (r_cmd == bmhq_pkg::CMD_REMOVE);
        o_stat.full          = (r_count == bmhq_pkg::CNT_W'(bmhq_pkg::DEPTH));
        o_stat.pos_bad       = (CMP_W'(r_pos) >= CMP_W'(r_count));
        o_stat.pos_is_last   = (bmhq_pkg::CNT_W'(r_node) == w_last);
        o_stat.node_zero     = (r_node == '0);
        o_stat.v_gt_rdata    = ($signed(r_val) > $signed(r_rdata));
        o_stat.left_out      = (w_left >= w_count_c);
        o_stat.right_out     = (w_right >= w_count_c);
        o_stat.rdata_gt_cand = ($signed(r_rdata) > $signed(r_cand));
        o_stat.cand_gt_v     = ($signed(r_cand) > $signed(r_val));
    end

    assign o_removed = r_o_removed;
    assign o_top     = r_o_top;
    assign o_count   = r_o_count;
    assign o_status  = r_o_status;

endmodule

FILE: hw/rtl/bmhq_ctrl.sv
module bmhq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bmhq_pkg::t_dp_cmd   o_cmd,
    input  bmhq_pkg::t_dp_stat  i_stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_RM_LAST,
        S_RM_GOT,
        S_RM_PAR,
        S_UP_CHK,
        S_UP_CMP,
        S_DN_CHK,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!i_stat.is_remove) begin
                    if (i_stat.full) begin
                        o_cmd.status_wr   = 1'b1;
                        o_cmd.status_code = bmhq_pkg::ST_FULL;
                        n_state           = S_DONE;
                    end else begin
                        o_cmd.ins_setup = 1'b1;
                        n_state         = S_UP_CHK;
                    end
                end else if (i_stat.pos_bad) begin
                    o_cmd.status_wr   = 1'b1;
                    o_cmd.status_code = bmhq_pkg::ST_NOT_OCC;
                    n_state           = S_DONE;
                end else begin
                    o_cmd.rd_sel        = bmhq_pkg::RD_POS;
                    o_cmd.load_node_pos = 1'b1;
                    n_state             = S_RM_LAST;
                end
            end
            S_RM_LAST: begin
                o_cmd.cap_removed = 1'b1;
                o_cmd.rd_sel      = bmhq_pkg::RD_LAST;
                n_state           = S_RM_GOT;
            end
            S_RM_GOT: begin
                // moved value lands in the value register, heap shrinks
                o_cmd.cap_last = 1'b1;
                o_cmd.rd_sel   = bmhq_pkg::RD_PARENT;
                if (i_stat.pos_is_last) begin
                    n_state = S_DONE;
                end else if (i_stat.node_zero) begin
                    n_state = S_DN_CHK;
                end else begin
                    n_state = S_RM_PAR;
                end
            end
            S_RM_PAR: begin
                if (i_stat.v_gt_rdata) begin
                    o_cmd.wr_en          = 1'b1;
                    o_cmd.wr_sel         = bmhq_pkg::WR_RDATA;
                    o_cmd.node_to_parent = 1'b1;
                    n_state              = S_UP_CHK;
                end else begin
                    n_state = S_DN_CHK;
                end
            end
            S_UP_CHK: begin
                if (i_stat.node_zero) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = bmhq_pkg::WR_VAL;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.rd_sel = bmhq_pkg::RD_PARENT;
                    n_state      = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                o_cmd.wr_en = 1'b1;
                if (i_stat.v_gt_rdata) begin
                    o_cmd.wr_sel         = bmhq_pkg::WR_RDATA;
                    o_cmd.node_to_parent = 1'b1;
                    n_state              = S_UP_CHK;
                end else begin
                    o_cmd.wr_sel = bmhq_pkg::WR_VAL;
                    n_state      = S_DONE;
                end
            end
            S_DN_CHK: begin
                if (i_stat.left_out) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = bmhq_pkg::WR_VAL;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.rd_sel = bmhq_pkg::RD_LEFT;
                    n_state      = S_DN_L;
                end
            end
            S_DN_L: begin
                o_cmd.cap_left = 1'b1;
                o_cmd.rd_sel   = bmhq_pkg::RD_RIGHT;
                n_state        = i_stat.right_out ? S_DN_CMP : S_DN_R;
            end
            S_DN_R: begin
                // right wins only when strictly greater
                o_cmd.cap_right = i_stat.rdata_gt_cand;
                n_state         = S_DN_CMP;
            end
            S_DN_CMP: begin
                o_cmd.wr_en = 1'b1;
                if (i_stat.cand_gt_v) begin
                    o_cmd.wr_sel       = bmhq_pkg::WR_CAND;
                    o_cmd.node_to_cand = 1'b1;
                    n_state            = S_DN_CHK;
                end else begin
                    o_cmd.wr_sel = bmhq_pkg::WR_VAL;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: dv/heap_queue_checker.sv
// Watches both item streams of the heap queue, keeps its own copy of the heap,
// and compares every result item with the oldest predicted one.
module heap_queue_checker
    import bmhq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [31:0] value, [41:32] position, [47:42] zero
    input  logic        s_axis_tuser,   // [0] command
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [79:0] m_axis_tdata,   // [31:0] removed, [63:32] top, [74:64] count,
                                        // [76:75] status, [79:77] zero
    output int          o_errors,
    output int          o_pending,
    output int          o_inserts,
    output int          o_removes,
    output int          o_full_refusals,
    output int          o_vacant_removes,
    output int          o_peak_fill
);

    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic signed [VALUE_W-1:0] removed;
        logic signed [VALUE_W-1:0] top;
        logic [CNT_W-1:0]          count;
        logic [STAT_W-1:0]         status;
    } t_heap_result;

    // shadow heap, same layout as the block: children of slot i at 2i+1, 2i+2
    logic signed [VALUE_W-1:0] heap_img [DEPTH];
    int                        fill;
    t_heap_result              awaited_results [$];

    int err_count;
    int result_idx;
    int n_ins, n_rem, n_full, n_vacant, peak;

    initial begin
        fill       = 0;
        err_count  = 0;
        result_idx = 0;
        n_ins      = 0;
        n_rem      = 0;
        n_full     = 0;
        n_vacant   = 0;
        peak       = 0;
    end

    task automatic report_mismatch(string msg);
        err_count++;
        if (err_count <= MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function automatic void swap_slots(int a, int b);
        logic signed [VALUE_W-1:0] t;
        t           = heap_img[a];
        heap_img[a] = heap_img[b];
        heap_img[b] = t;
    endfunction

    // climb while strictly greater than the parent
    function automatic void bubble_up(int node);
        int parent;
        while (node > 0) begin
            parent = (node - 1) / 2;
            if (heap_img[node] <= heap_img[parent])
                break;
            swap_slots(node, parent);
            node = parent;
        end
    endfunction

    // descend toward the larger child; left wins a tie
    function automatic void sink_down(int node);
        int left;
        int right;
        int pick;
        while (1) begin
            left  = 2 * node + 1;
            right = left + 1;
            if (left >= fill)
                break;
            pick = left;
            if (right < fill && heap_img[right] > heap_img[left])
                pick = right;
            if (heap_img[pick] <= heap_img[node])
                break;
            swap_slots(pick, node);
            node = pick;
        end
    endfunction

    function automatic t_heap_result apply_command(logic cmd, logic signed [VALUE_W-1:0] value,
                                                   logic [POS_W-1:0] pos);
        t_heap_result r;
        int           slot;
        r        = '0;
        r.status = ST_OK;
        slot     = int'(pos);
        if (cmd == CMD_INSERT) begin
            if (fill >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                heap_img[fill] = value;
                fill++;
                bubble_up(fill - 1);
            end
        end else if (slot >= fill) begin
            r.status = ST_NOT_OCC;
        end else begin
            // last element fills the hole, then moves whichever way it must
            r.removed      = heap_img[slot];
            heap_img[slot] = heap_img[fill - 1];
            fill--;
            if (slot < fill) begin
                if (slot > 0 && heap_img[slot] > heap_img[(slot - 1) / 2])
                    bubble_up(slot);
                else
                    sink_down(slot);
            end
        end
        r.count = CNT_W'(fill);
        r.top   = (fill > 0) ? heap_img[0] : '0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_heap_result want;
        t_heap_result got;
        if (!i_rst_n) begin
            fill = 0;
            awaited_results.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                want = apply_command(s_axis_tuser, s_axis_tdata[VALUE_W-1:0],
                                     s_axis_tdata[VALUE_W +: POS_W]);
                awaited_results = {awaited_results, want};
                if (s_axis_tuser == CMD_INSERT) n_ins++;
                else                            n_rem++;
                if (want.status == ST_FULL)    n_full++;
                if (want.status == ST_NOT_OCC) n_vacant++;
                if (fill > peak) peak = fill;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.removed = m_axis_tdata[31:0];
                got.top     = m_axis_tdata[63:32];
                got.count   = m_axis_tdata[74:64];
                got.status  = m_axis_tdata[76:75];
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing pending",
                                              result_idx));
                end else begin
                    want = awaited_results.pop_front();
                    if (got.removed !== want.removed)
                        report_mismatch($sformatf("result %0d removed_value %0d, want %0d",
                                                  result_idx, got.removed, want.removed));
                    if (got.top !== want.top)
                        report_mismatch($sformatf("result %0d top_value %0d, want %0d",
                                                  result_idx, got.top, want.top));
                    if (got.count !== want.count)
                        report_mismatch($sformatf("result %0d count %0d, want %0d",
                                                  result_idx, got.count, want.count));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("result %0d status %0d, want %0d",
                                                  result_idx, got.status, want.status));
                end
                result_idx++;
            end
        end
        o_errors         <= err_count;
        o_pending        <= awaited_results.size();
        o_inserts        <= n_ins;
        o_removes        <= n_rem;
        o_full_refusals  <= n_full;
        o_vacant_removes <= n_vacant;
        o_peak_fill      <= peak;
    end

endmodule

FILE: dv/tb_top.sv
// Heap queue bench: directed corner items first, then a random fill / hold-full /
// drain pattern. Stimulus changes on the falling edge; the checker samples on the
// rising edge and owns all prediction.
module tb_top;
    import bmhq_pkg::*;

    localparam int RAND_ITEMS  = 1825;
    localparam int CALM_ITEMS  = 200;   // tail of the run with no idling at all
    localparam int FULL_HOLD   = 24;    // items spent banging on a full heap
    localparam int DRAIN_WAIT  = 100;
    localparam int STALL_LIMIT = 2000;  // cycles with no item moving on either side

    typedef enum {
        FILLING,
        HELD_FULL,
        DRAINING
    } t_stim_phase;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;    // [31:0] value, [41:32] position, [47:42] zero
    logic        s_axis_tuser  = 1'b0;  // [0] command: 0 insert, 1 remove at position
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;          // [31:0] removed, [63:32] top, [74:64] count,
                                        // [76:75] status, [79:77] zero

    int errors, pending, inserts, removes, full_refusals, vacant_removes, peak_fill;

    // occupancy as the stimulus sees it, used to aim slot positions and to switch phases
    int level = 0;
    bit calm  = 1'b0;
    int rx_hold = 0;
    int idle_cycles = 0;

    always #10 i_clk = ~i_clk;

    binary_max_heap_queue_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    heap_queue_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tuser     (s_axis_tuser),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .o_errors         (errors),
        .o_pending        (pending),
        .o_inserts        (inserts),
        .o_removes        (removes),
        .o_full_refusals  (full_refusals),
        .o_vacant_removes (vacant_removes),
        .o_peak_fill      (peak_fill)
    );

    // Result side back-pressure: random stall bursts, no new burst starts while calm.
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            rx_hold = $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: a stuck handshake ends the run.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Called and returns on a falling edge. Optional gap first, then hold the item
    // until the rising edge that takes it.
    task automatic send_item(logic cmd, logic [VALUE_W-1:0] value, logic [POS_W-1:0] pos);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {6'b0, pos, value};
        do @(posedge i_clk); while (!s_axis_tready);
        if (cmd == CMD_INSERT) begin
            if (level < DEPTH) level++;
        end else if (int'(pos) < level) begin
            level--;
        end
        @(negedge i_clk);
    endtask

    // Extremes, a narrow band that makes ties, or anything.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return VALUE_W'($urandom_range(0, 15)) - VALUE_W'(8);
            default: return $urandom;
        endcase
    endfunction

    // Occupied slot (root and last slot favored) or a vacant one when asked; any slot once full.
    function automatic logic [POS_W-1:0] pick_slot(bit occupied);
        if (occupied && level > 0) begin
            case ($urandom_range(0, 5))
                0, 1:    return '0;
                2:       return POS_W'(level - 1);
                default: return POS_W'($urandom_range(0, level - 1));
            endcase
        end else if (level < DEPTH) begin
            return POS_W'($urandom_range(level, DEPTH - 1));
        end else begin
            return POS_W'($urandom_range(0, DEPTH - 1));
        end
    endfunction

    initial begin
        t_stim_phase phase;
        int          roll;
        int          hold_left;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed corners ----
        // removes on an empty heap, lowest and highest position
        send_item(CMD_REMOVE, 32'hFFFF_FFFF, 10'd0);
        send_item(CMD_REMOVE, 32'h0000_0000, 10'd1023);
        // extremes and ties; position bits set on an insert must be ignored
        send_item(CMD_INSERT, 32'h7FFF_FFFF, 10'd1023);
        send_item(CMD_INSERT, 32'h8000_0000, 10'd0);
        send_item(CMD_INSERT, 32'h0000_0000, 10'h2AA);
        send_item(CMD_INSERT, 32'hFFFF_FFFF, 10'h155);
        send_item(CMD_INSERT, 32'd5, 10'd0);
        send_item(CMD_INSERT, 32'd5, 10'd0);
        send_item(CMD_INSERT, 32'd5, 10'd0);
        // seven stored: slot 7 is just past the end, slot 6 is the last one
        send_item(CMD_REMOVE, 32'd0, 10'd7);
        send_item(CMD_REMOVE, 32'd0, 10'd6);
        send_item(CMD_REMOVE, 32'd0, 10'd2);
        send_item(CMD_REMOVE, 32'hFFFF_FFFF, 10'd0);
        send_item(CMD_INSERT, 32'h7FFF_FFFF, 10'd0);   // ties with nothing left at top
        // empty it from the root
        repeat (5) send_item(CMD_REMOVE, 32'd0, 10'd0);
        // 10,1,9,0,0,8 then remove slot 3: the moved 8 beats parent 1 and climbs
        send_item(CMD_INSERT, 32'd10, 10'd0);
        send_item(CMD_INSERT, 32'd1, 10'd0);
        send_item(CMD_INSERT, 32'd9, 10'd0);
        send_item(CMD_INSERT, 32'd0, 10'd0);
        send_item(CMD_INSERT, 32'd0, 10'd0);
        send_item(CMD_INSERT, 32'd8, 10'd0);
        send_item(CMD_REMOVE, 32'd0, 10'd3);

        // ---- random: fill to the brim, hammer it full, then drain ----
        phase     = FILLING;
        hold_left = FULL_HOLD;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            // idle-free windows every few hundred items, and the whole tail
            calm = (n % 300 < 40) || (n >= RAND_ITEMS - CALM_ITEMS);
            roll = $urandom_range(0, 99);
            case (phase)
                FILLING: begin
                    if (roll < 93)      send_item(CMD_INSERT, pick_value(), pick_slot(1'b0));
                    else if (roll < 98) send_item(CMD_REMOVE, $urandom, pick_slot(1'b1));
                    else                send_item(CMD_REMOVE, $urandom, pick_slot(1'b0));
                    if (level == DEPTH) phase = HELD_FULL;
                end
                HELD_FULL: begin
                    // mostly refused inserts; the odd remove opens one slot again
                    if (roll < 70) send_item(CMD_INSERT, pick_value(), pick_slot(1'b0));
                    else           send_item(CMD_REMOVE, $urandom, pick_slot(1'b1));
                    hold_left--;
                    if (hold_left == 0) phase = DRAINING;
                end
                default: begin
                    if (roll < 80)      send_item(CMD_REMOVE, $urandom, pick_slot(1'b1));
                    else if (roll < 88) send_item(CMD_REMOVE, $urandom, pick_slot(1'b0));
                    else                send_item(CMD_INSERT, pick_value(), pick_slot(1'b0));
                end
            endcase
        end
        s_axis_tvalid <= 1'b0;

        // let every predicted result come back, then watch for strays
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("Run covered %0d items: %0d inserts, %0d removes; heap peaked at %0d of %0d.",
                 inserts + removes, inserts, removes, peak_fill, DEPTH);
        $display("Inserts refused on a full heap: %0d; removes of vacant slots: %0d.",
                 full_refusals, vacant_removes);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
